@@ hdl/murmur64a_byte_hash_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hash core
// Shared forms for the checks placed at the end of the core's modules.
// ----------------------------------------------------------------------------
`ifndef MURMUR64A_BYTE_HASH_CORE_ASSERT_SVH
`define MURMUR64A_BYTE_HASH_CORE_ASSERT_SVH

// Same-cycle implication.
`define MH64_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define MH64_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ hdl/mh64_pkg.sv @@
// ----------------------------------------------------------------------------
// mh64_pkg
// Constants, types and helpers shared by the byte hash core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

   localparam logic [63:0] MULT    = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MULT_LO = MULT[31:0];
   localparam logic [31:0] MULT_HI = MULT[63:32];
   localparam logic [63:0] SEED    = 64'h00000000e17a1465;
   localparam int          SHIFT   = 47;

   // Work queue between the front and back parts.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   // Front pipeline stages that hold items not yet in the queue.
   localparam int FRONT_STAGES = 4;
   localparam int INFL_W       = $clog2(FRONT_STAGES + 1);
   localparam int CREDIT_W     = CNT_W + 1;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FULL,
      KIND_TAIL
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_MUL
   } back_state_type;

   typedef struct packed {
      logic [63:0] value;   // mixed chunk or masked tail bytes
      logic [63:0] init;    // seed XOR length product, used when first is set
      kind_type    kind;
      logic        first;
      logic        last;
   } queue_item_type;

   function automatic logic [63:0] xorshift(input logic [63:0] x);
      xorshift = x ^ (x >> SHIFT);
   endfunction

   function automatic logic [63:0] tail_mask(input logic [2:0] count);
      tail_mask = (64'd1 << {count, 3'b000}) - 64'd1;
   endfunction

endpackage

`default_nettype wire

@@ hdl/mh64_mul.sv @@
// ----------------------------------------------------------------------------
// mh64_mul
// Multiply by the hash multiplier, mod 2^64, from registered 32x32 partials.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_mul
   import mh64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [63:0] a,
   output logic      [63:0] p
);

   logic [63:0] lo_ff, lo_in;
   logic [31:0] hl_ff, hl_in;
   logic [31:0] lh_ff, lh_in;

   // Only the low halves of the cross products reach bits 63:32.
   assign lo_in = a[31:0] * MULT_LO;
   assign hl_in = a[63:32] * MULT_LO;
   assign lh_in = a[31:0] * MULT_HI;

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hl_ff <= hl_in;
      lh_ff <= lh_in;
   end

   assign p = lo_ff + {hl_ff + lh_ff, 32'b0};

endmodule

`default_nettype wire

@@ hdl/mh64_front.sv @@
// ----------------------------------------------------------------------------
// mh64_front
// Accepts words, classifies them and mixes full chunks in a fixed pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_front
   import mh64_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [63:0]          req_word,
   input  wire logic [3:0]           req_byte_count,
   input  wire logic                 req_first,
   input  wire logic                 req_last,
   input  wire logic [31:0]          req_total_length,
   input  wire logic [CNT_W-1:0]     fifo_count,
   output logic                      push,
   output queue_item_type            push_item
);

   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [63:0] word0_ff;
   logic [3:0]  cnt0_ff;
   logic        first0_ff, last0_ff;
   logic [31:0] len0_ff;

   kind_type    kind0, kind1_ff, kind2_ff, kind3_ff;
   logic [63:0] data0, data1_ff, data2_ff, data3_ff;
   logic        first1_ff, first2_ff, first3_ff;
   logic        last1_ff, last2_ff, last3_ff;
   logic [63:0] k2_ff, init2_ff, init3_ff;
   logic [63:0] prod_a, prod_b, prod_c;

   logic                accept;
   logic [INFL_W-1:0]   inflight;
   logic [CREDIT_W-1:0] credit_used;

   // Hold off input while queue slots are all spoken for.
   assign inflight = {{(INFL_W-1){1'b0}}, v0_ff} + {{(INFL_W-1){1'b0}}, v1_ff}
                   + {{(INFL_W-1){1'b0}}, v2_ff} + {{(INFL_W-1){1'b0}}, v3_ff};
   assign credit_used = CREDIT_W'(fifo_count) + CREDIT_W'(inflight);
   assign req_full = credit_used >= CREDIT_W'(FIFO_DEPTH);
   assign accept = req_push && !req_full;

   always_comb begin
      if (cnt0_ff == 4'd0) begin
         kind0 = KIND_NONE;
      end else if (cnt0_ff[3]) begin
         kind0 = KIND_FULL;
      end else begin
         kind0 = KIND_TAIL;
      end
      data0 = word0_ff & tail_mask(cnt0_ff[2:0]);
   end

   mh64_mul u_mul_word (
      .clock (clock),
      .a     (word0_ff),
      .p     (prod_a)
   );

   mh64_mul u_mul_len (
      .clock (clock),
      .a     ({32'b0, len0_ff}),
      .p     (prod_b)
   );

   mh64_mul u_mul_mix (
      .clock (clock),
      .a     (xorshift(k2_ff)),
      .p     (prod_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      word0_ff  <= req_word;
      cnt0_ff   <= req_byte_count;
      first0_ff <= req_first;
      last0_ff  <= req_last;
      len0_ff   <= req_total_length;

      kind1_ff  <= kind0;
      data1_ff  <= data0;
      first1_ff <= first0_ff;
      last1_ff  <= last0_ff;

      kind2_ff  <= kind1_ff;
      data2_ff  <= data1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      k2_ff     <= prod_a;
      init2_ff  <= SEED ^ prod_b;

      kind3_ff  <= kind2_ff;
      data3_ff  <= data2_ff;
      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      init3_ff  <= init2_ff;
   end

   assign push            = v3_ff;
   assign push_item.value = (kind3_ff == KIND_FULL) ? prod_c : data3_ff;
   assign push_item.init  = init3_ff;
   assign push_item.kind  = kind3_ff;
   assign push_item.first = first3_ff;
   assign push_item.last  = last3_ff;

endmodule

`default_nettype wire

@@ hdl/mh64_fifo.sv @@
// ----------------------------------------------------------------------------
// mh64_fifo
// Short work queue between the front pipeline and the hash sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_fifo
   import mh64_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire queue_item_type    push_item,
   input  wire logic              pop,
   output queue_item_type         head,
   output logic                   empty,
   output logic [CNT_W-1:0]       count
);

   `include "murmur64a_byte_hash_core_assert.svh"

   queue_item_type      slots [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

   assign head  = slots[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   `MH64_ASSERT_NOW(a_no_overflow, clock, reset, push && !pop, count_ff != CNT_W'(FIFO_DEPTH))
   `MH64_ASSERT_NOW(a_no_underflow, clock, reset, pop, count_ff != '0)
   `MH64_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

@@ hdl/mh64_back.sv @@
// ----------------------------------------------------------------------------
// mh64_back
// Folds queued words into the running hash and holds the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_back
   import mh64_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire queue_item_type  head,
   input  wire logic            fifo_empty,
   output logic                 pop,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output logic [63:0]          rsp_hash
);

   `include "murmur64a_byte_hash_core_assert.svh"

   back_state_type state_ff, state_in;
   logic [63:0]    h_ff, h_in;
   logic           last_ff, last_in;
   logic           out_valid_ff, out_valid_in;
   logic [63:0]    out_hash_ff, out_hash_in;
   logic           out_load;
   logic           go;
   logic [63:0]    h_sel;
   logic [63:0]    mul_a, prod;

   assign h_sel = head.first ? head.init : h_ff;
   // A last word may only start once the result slot is free or being freed.
   assign go = (state_ff == BK_IDLE) && !fifo_empty
            && (!head.last || !out_valid_ff || rsp_pop);
   assign mul_a = h_sel ^ head.value;

   mh64_mul u_mul_hash (
      .clock (clock),
      .a     (mul_a),
      .p     (prod)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (go && head.kind != KIND_NONE) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      h_in        = h_ff;
      last_in     = last_ff;
      out_load    = 1'b0;
      out_hash_in = out_hash_ff;
      case (state_ff)
         BK_IDLE: begin
            if (go) begin
               pop     = 1'b1;
               last_in = head.last;
               if (head.kind == KIND_NONE) begin
                  h_in        = h_sel;
                  out_load    = head.last;
                  out_hash_in = xorshift(h_sel);
               end
            end
         end
         BK_MUL: begin
            h_in        = prod;
            out_load    = last_ff;
            out_hash_in = xorshift(prod);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         h_ff         <= '0;
         out_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hash_ff <= out_hash_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_hash  = out_hash_ff;

   `MH64_ASSERT_NEXT(a_mul_one_cycle, clock, reset, state_ff == BK_MUL, state_ff == BK_IDLE)
   `MH64_ASSERT_NEXT(a_result_held, clock, reset, out_valid_ff && !rsp_pop, out_valid_ff && $stable(out_hash_ff))
   `MH64_ASSERT_NEXT(a_idle_hash_held, clock, reset, state_ff == BK_IDLE && !go, $stable(h_ff))

endmodule

`default_nettype wire

@@ hdl/murmur64a_byte_hash_core.sv @@
// ----------------------------------------------------------------------------
// murmur64a_byte_hash_core
// 64-bit multiply-xorshift byte hash over little-endian message words.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_* and raise req_push; a word is taken at an edge
//   where req_full is low. Mark a message's first word with req_first (it
//   also carries req_total_length) and its final word with req_last.
//   req_byte_count is 8 for a full chunk, 1-7 for a tail, 0 for no data.
//   Result queue: while rsp_empty is low rsp_hash holds the oldest hash;
//   raise rsp_pop to take it. One hash per word marked last.
//   Path: the last word passes the four front stages, the work queue and
//   the back multiply before rsp_empty falls; a word with no data skips the multiply.
//   Sequencer: the back sequencer takes no new word while its running-hash
//   multiply (a two-step split 64-bit multiply) is under way; words with no
//   data skip that multiply. Chunk mixing runs in a four-stage front pipeline.
//   Stall: when rsp_pop stays low, one result waits in the output register
//   and the eight-entry work queue keeps filling; req_full rises once the
//   queue and the front pipeline are spoken for.
//   Reset: synchronous; clears the queue, the pipeline valids, the result
//   valid flag and sets the running hash to zero. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur64a_byte_hash_core
   import mh64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_first,
   input  wire logic        req_last,
   input  wire logic [31:0] req_total_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [63:0]      rsp_hash
);

   logic             push;
   queue_item_type   push_item;
   logic             pop;
   queue_item_type   head;
   logic             fifo_empty;
   logic [CNT_W-1:0] fifo_count;

   mh64_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_word         (req_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_last         (req_last),
      .req_total_length (req_total_length),
      .fifo_count       (fifo_count),
      .push             (push),
      .push_item        (push_item)
   );

   mh64_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (fifo_empty),
      .count     (fifo_count)
   );

   mh64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_hash   (rsp_hash)
   );

endmodule

`default_nettype wire

@@ verif/tb_murmur64a_byte_hash_core.sv @@
// ----------------------------------------------------------------------------
// tb_murmur64a_byte_hash_core
// Self-checking bench for the byte hash core. Messages of random length are
// split into words and pushed in bursts. A local model folds each taken word
// into its own running hash and queues the digest that a final word yields.
// Popped hashes are checked in order against that queue.
// ----------------------------------------------------------------------------

module tb_murmur64a_byte_hash_core;
   import mh64_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_WORDS  = 1700;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  byte_count;
      logic        first;
      logic        last;
      logic [31:0] total_length;
      bit          wait_drain;   // hold this item until all hashes are out
   } msg_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic [31:0] req_total_length = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_hash;

   msg_word_type word_queue[$];
   logic [63:0]  expected_hashes[$];
   logic [63:0]  chain_hash = '0;

   bit          item_taken = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic [15:0] pop_pattern = 16'hffff;
   logic [3:0]  pat_pos = '0;

   murmur64a_byte_hash_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_word         (req_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_last         (req_last),
      .req_total_length (req_total_length),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_hash         (rsp_hash)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit steady_window();
      return (cycle_count % 1600) < 320;
   endfunction

   // Fold one taken word into the running hash; digest is valid when emit is set.
   task automatic fold_word(input logic [63:0] w, input logic [3:0] n, input logic f,
                            input logic l, input logic [31:0] len,
                            output logic emit, output logic [63:0] digest);
      logic [63:0] h;
      logic [63:0] k;
      h = chain_hash;
      if (f) h = SEED ^ ({32'd0, len} * MULT);
      if (n >= 4'd8) begin
         k = w * MULT;
         k = k ^ (k >> SHIFT);
         k = k * MULT;
         h = (h ^ k) * MULT;
      end else if (n != 4'd0) begin
         // drop bytes at and above the count
         h = (h ^ (w & ((64'd1 << (n * 8)) - 64'd1))) * MULT;
      end
      chain_hash = h;
      emit = l;
      digest = h ^ (h >> SHIFT);
   endtask

   task automatic queue_word(input logic [63:0] w, input logic [3:0] n, input logic f,
                             input logic l, input logic [31:0] len, input bit hold);
      msg_word_type item;
      item.word = w;
      item.byte_count = n;
      item.first = f;
      item.last = l;
      item.total_length = len;
      item.wait_drain = hold;
      word_queue.push_back(item);
   endtask

   task automatic add_message(input int unsigned nbytes, input logic [31:0] len_field,
                              input bit hold);
      int unsigned left;
      logic [3:0]  n;
      bit          f;
      left = nbytes;
      f = 1'b1;
      do begin
         n = (left >= 8) ? 4'd8 : left[3:0];
         left -= n;
         queue_word(rand64(), n, f, left == 0, f ? len_field : $urandom, hold && f);
         f = 1'b0;
      end while (left != 0);
   endtask

   // Sender: present the head item, then idle in gaps between bursts.
   always @(negedge clock) begin
      logic drive;
      drive = req_push;
      if (!reset) begin
         if (item_taken) begin
            item_taken = 1'b0;
            void'(word_queue.pop_front());
            drive = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end
         if (steady_window()) gap_left = 0;
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_queue.size() > 0 &&
                         !(word_queue[0].wait_drain && expected_hashes.size() != 0)) begin
               req_word <= word_queue[0].word;
               req_byte_count <= word_queue[0].byte_count;
               req_first <= word_queue[0].first;
               req_last <= word_queue[0].last;
               req_total_length <= word_queue[0].total_length;
               drive = 1'b1;
            end
         end
      end
      req_push <= drive;
   end

   // Receiver: pop on a rotating pattern with occasional long stalls, or always in steady windows.
   always @(negedge clock) begin
      logic take;
      take = 1'b0;
      if (!reset) begin
         if (steady_window()) begin
            take = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            take = pop_pattern[pat_pos];
            if (pat_pos == 4'd15) begin
               pop_pattern = ($urandom_range(0, 1) == 0) ? 16'($urandom | $urandom)
                                                         : 16'($urandom & $urandom);
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(8, 40);
            end
            pat_pos++;
         end
      end
      rsp_pop <= take;
   end

   // Predict on each taken word, check each popped hash.
   always @(posedge clock) begin
      logic        emit;
      logic [63:0] digest;
      logic [63:0] want;
      if (!reset) begin
         cycle_count++;
         idle_cycles++;
         if (req_push && !req_full) begin
            item_taken = 1'b1;
            idle_cycles = 0;
            fold_word(req_word, req_byte_count, req_first, req_last, req_total_length,
                      emit, digest);
            if (emit) expected_hashes.push_back(digest);
         end
         if (rsp_pop && !rsp_empty) begin
            idle_cycles = 0;
            if (expected_hashes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected hash: expected none, actual %h", $time, rsp_hash);
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash !== want) begin
                  mismatches++;
                  $display("%0t: hash mismatch: expected %h, actual %h",
                           $time, want, rsp_hash);
               end
            end
         end
      end
   end

   initial begin
      wait (!reset);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL murmur64a_byte_hash_core");
      $finish;
   end

   initial begin
      int unsigned random_words;
      int unsigned next_hold;
      int unsigned prior;
      int unsigned nbytes;
      int unsigned pick;
      logic [31:0] len_field;

      // directed: corner cases of counts, flags and lengths
      queue_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd0, 1'b0);     // no first word after reset
      queue_word('0, 4'd0, 1'b1, 1'b1, 32'd0, 1'b0);           // empty message
      queue_word('1, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0);
      for (int n = 1; n <= 7; n++)                              // tails with stray bytes set
         queue_word('1, n[3:0], 1'b1, 1'b1, n, 1'b0);
      for (int n = 9; n <= 15; n++)                             // oversized counts
         queue_word(rand64(), n[3:0], 1'b1, 1'b1, 32'd8, 1'b0);
      queue_word('0, 4'd8, 1'b1, 1'b0, 32'hffff_ffff, 1'b0);    // length mismatch
      queue_word(rand64(), 4'd3, 1'b0, 1'b0, $urandom, 1'b0);   // tail that is not last
      queue_word('1, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0);
      queue_word(rand64(), 4'd5, 1'b0, 1'b1, 32'd0, 1'b0);     // continue after last
      queue_word(rand64(), 4'd0, 1'b0, 1'b1, '1, 1'b1);

      // random: mostly well-formed messages, some noise words
      random_words = 0;
      next_hold = 150;
      while (random_words < RANDOM_WORDS) begin
         prior = word_queue.size();
         if ($urandom_range(0, 9) == 0) begin
            queue_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom, 1'b0);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      nbytes = 0;
            else if (pick < 80) nbytes = $urandom_range(1, 24);
            else if (pick < 96) nbytes = $urandom_range(25, 120);
            else                nbytes = $urandom_range(121, 400);
            len_field = ($urandom_range(0, 11) == 0) ? $urandom : nbytes;
            add_message(nbytes, len_field, random_words >= next_hold);
            if (random_words >= next_hold) next_hold += 300;
         end
         random_words += word_queue.size() - prior;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (word_queue.size() != 0 || req_push) @(posedge clock);
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS murmur64a_byte_hash_core");
      else
         $display("FAIL murmur64a_byte_hash_core");
      $finish;
   end

endmodule
